/* hw/rtl/rcs_pkg.sv */
// Shared types and constants of the raycast column setup block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rcs_pkg;

  localparam int COL_W      = 10;
  localparam int POS_W      = 24;
  localparam int DIR_W      = 18;
  localparam int RAY_W      = 19;
  localparam int CELL_W     = 8;
  localparam int FRAC_W     = 16;
  localparam int DIST_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int RAY_MAX = 262143;
  localparam int RAY_MIN = -262144;

  // Reciprocal divider: quotient bits retired per stage, plus one setup stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = 1 + DIST_W / DIV_STEPS;

  typedef logic signed [RAY_W-1:0] ray_t;
  typedef logic [DIST_W-1:0]       dist_t;

  localparam dist_t DIST_SAT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_t;

endpackage

`default_nettype wire

/* hw/rtl/rcs_recip_div.sv */
// Pipelined reciprocal unit: delta = floor(2^32 / |ray|), saturated for |ray| <= 1.
// Depends on rcs_pkg; stage enables come from the top level's valid chain.
`default_nettype none

module rcs_recip_div (
  input  logic                          clk,
  input  logic [rcs_pkg::DIV_STAGES-1:0] en,
  input  rcs_pkg::ray_t                 ray_i,
  output rcs_pkg::ray_t                 ray_o,
  output rcs_pkg::dist_t                delta_o
);
  import rcs_pkg::*;

  localparam int REM_W = RAY_W + 1;

  ray_t             ray_r [DIV_STAGES];
  logic [RAY_W-1:0] mag_r [DIV_STAGES];
  logic [REM_W-1:0] rem_r [DIV_STAGES];
  dist_t            q_r   [DIV_STAGES];
  logic             sat_r [DIV_STAGES];

  logic [RAY_W-1:0] mag_nxt;

  // Setup: take the magnitude; the leading dividend bit leaves remainder 1
  assign mag_nxt = ray_i[RAY_W-1] ? RAY_W'(-ray_i) : RAY_W'(ray_i);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ray_r[0] <= ray_i;
      mag_r[0] <= mag_nxt;
      sat_r[0] <= (mag_nxt <= RAY_W'(1));
      rem_r[0] <= REM_W'(1);
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_W-1:0] rem_nxt;
    logic [REM_W-1:0] rem_sh;
    dist_t            q_nxt;

    // Restoring steps: shift in a zero dividend bit, subtract when it fits
    always_comb begin
      rem_nxt = rem_r[s-1];
      q_nxt   = q_r[s-1];
      rem_sh  = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_sh = {rem_nxt[REM_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, mag_r[s-1]}) begin
          rem_nxt = rem_sh - {1'b0, mag_r[s-1]};
          q_nxt   = {q_nxt[DIST_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_nxt[DIST_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        ray_r[s] <= ray_r[s-1];
        mag_r[s] <= mag_r[s-1];
        sat_r[s] <= sat_r[s-1];
        rem_r[s] <= rem_nxt;
        q_r[s]   <= q_nxt;
      end
    end
  end

  assign ray_o   = ray_r[DIV_STAGES-1];
  assign delta_o = sat_r[DIV_STAGES-1] ? DIST_SAT : q_r[DIV_STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/raycast_column_setup.sv */
// Top level of the raycast column setup block: config registers, ray pipeline, outputs.
// Depends on rcs_pkg and rcs_recip_div (one reciprocal unit per axis).
//
// Usage:
//   Write player position, view direction and camera plane through the cfg
//   channel (cfg_ready is always high; index 0..5, other indexes are dropped).
//   Write only while the pipeline is empty.
//   Send one screen column per item on the in channel; each item yields one
//   result item on the out channel with ray direction, player cell, step
//   signs, grid-line distances (delta) and first-side distances.
// Pipeline: an accepted item passes 4 ray stages, 17 reciprocal stages,
//   1 side multiply stage and the output register before it shows on out_valid.
// Throughput: one item per cycle while the output is not held by out_stall.
// Stall: a stage holds while it is full and the one after it is holding, so
//   out_stall backs up only as far as the pipeline is full; bubbles collapse
//   and in_stall rises only when every stage holds an item.
// Reset: clears all valid bits and returns the config registers to their
//   defaults (view direction 1.0 along x, camera plane about 0.66 along y).
`default_nettype none

module raycast_column_setup #(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rcs_pkg::COL_W-1:0]      in_column,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rcs_pkg::ray_t                  out_ray_x,
  output rcs_pkg::ray_t                  out_ray_y,
  output logic [rcs_pkg::CELL_W-1:0]     out_cell_x,
  output logic [rcs_pkg::CELL_W-1:0]     out_cell_y,
  output logic                           out_step_x_neg,
  output logic                           out_step_y_neg,
  output rcs_pkg::dist_t                 out_delta_x,
  output rcs_pkg::dist_t                 out_delta_y,
  output rcs_pkg::dist_t                 out_side_x,
  output rcs_pkg::dist_t                 out_side_y
);
  import rcs_pkg::*;

  // Camera numerator 2*column - SCREEN_WIDTH and plane product widths
  localparam int SW_LOG = $clog2(SCREEN_WIDTH);
  localparam int CAM_W  = ((COL_W + 1 > SW_LOG) ? COL_W + 1 : SW_LOG) + 1;
  localparam int PW     = DIR_W + CAM_W;
  localparam int SUM_W  = PW + 2;
  localparam int REM_W  = SW_LOG + 1;

  // Floor division by SCREEN_WIDTH: bias the product non-negative, multiply
  // by floor(2^PW / W), then fix the quotient with one compare.
  localparam longint OFS_Q = ((64'd1 << (PW - 2)) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
  localparam longint OFS   = OFS_Q * SCREEN_WIDTH;
  localparam longint RECIP = (64'd1 << PW) / SCREEN_WIDTH;

  localparam logic signed [SUM_W-1:0] RAY_MAX_S = SUM_W'(RAY_MAX);
  localparam logic signed [SUM_W-1:0] RAY_MIN_S = SUM_W'(RAY_MIN);

  // Stage map: 0 plane product, 1 reciprocal multiply, 2 remainder,
  // 3 ray sum, then the divider, then side multiply, then output register.
  localparam int DIV_BASE = 4;
  localparam int MUL_STG  = DIV_BASE + DIV_STAGES;
  localparam int NST      = MUL_STG + 2;

  localparam int PROD_W = FRAC_W + 1 + DIST_W;

  // ---------------------------------------------------------------- config
  logic [POS_W-1:0]        pos_r   [2];
  logic signed [DIR_W-1:0] dir_r   [2];
  logic signed [DIR_W-1:0] plane_r [2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      dir_r[0]   <= DIR_W'(65536);
      dir_r[1]   <= '0;
      plane_r[0] <= '0;
      plane_r[1] <= DIR_W'(43254);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POS_X:   pos_r[0]   <= cfg_data[POS_W-1:0];
        CFG_POS_Y:   pos_r[1]   <= cfg_data[POS_W-1:0];
        CFG_DIR_X:   dir_r[0]   <= cfg_data[DIR_W-1:0];
        CFG_DIR_Y:   dir_r[1]   <= cfg_data[DIR_W-1:0];
        CFG_PLANE_X: plane_r[0] <= cfg_data[DIR_W-1:0];
        CFG_PLANE_Y: plane_r[1] <= cfg_data[DIR_W-1:0];
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  // ------------------------------------------------------- valid / enables
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  // A stage loads when some stage at or after it is empty, or the sink takes
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !out_stall || !(&v_r[NST-1:k]);
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ------------------------------------------------------------ datapath
  logic signed [CAM_W-1:0] cam;

  assign cam = CAM_W'($signed({1'b0, in_column, 1'b0})) - CAM_W'(SCREEN_WIDTH);

  ray_t             ray_out_r   [2];
  logic [CELL_W-1:0] cell_out_r [2];
  dist_t            delta_out_r [2];
  dist_t            side_out_r  [2];

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [PW-1:0]    p_r;
    logic [PW-1:0]           n_nxt;
    logic [2*PW-1:0]         prod_q;
    logic [PW-1:0]           n_r;
    logic [PW-1:0]           q0_r;
    logic [PW-1:0]           qw;
    logic [PW-1:0]           q1_r;
    logic [REM_W-1:0]        rem_r;
    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] rs;
    ray_t                    ray_nxt;
    ray_t                    ray_r;
    ray_t                    ray_d;
    dist_t                   delta_d;
    logic [FRAC_W:0]         frac;
    logic [FRAC_W:0]         f;
    ray_t                    ray_m_r;
    dist_t                   delta_m_r;
    logic [PROD_W-1:0]       side_prod_r;
    logic [PROD_W-FRAC_W-1:0] side_full;

    // Stage 0: plane times camera numerator
    always_ff @(posedge clk) begin
      if (en[0]) p_r <= plane_r[a] * cam;
    end

    // Stage 1: bias non-negative, multiply by the width reciprocal
    assign n_nxt  = PW'(p_r) + PW'(OFS);
    assign prod_q = {{PW{1'b0}}, n_nxt} * (2 * PW)'(RECIP);

    always_ff @(posedge clk) begin
      if (en[1]) begin
        n_r  <= n_nxt;
        q0_r <= prod_q[2*PW-1:PW];
      end
    end

    // Stage 2: remainder of the estimate, below twice the width
    assign qw = q0_r * PW'(SCREEN_WIDTH);

    always_ff @(posedge clk) begin
      if (en[2]) begin
        q1_r  <= q0_r;
        rem_r <= REM_W'(n_r - qw);
      end
    end

    // Stage 3: correct the quotient, remove bias, add view direction, clamp
    always_comb begin
      qs = $signed({2'b00, q1_r}) + SUM_W'(rem_r >= REM_W'(SCREEN_WIDTH)) - SUM_W'(OFS_Q);
      rs = qs + SUM_W'(dir_r[a]);
      if (rs > RAY_MAX_S)      ray_nxt = RAY_W'(RAY_MAX);
      else if (rs < RAY_MIN_S) ray_nxt = RAY_W'(RAY_MIN);
      else                     ray_nxt = RAY_W'(rs);
    end

    always_ff @(posedge clk) begin
      if (en[3]) ray_r <= ray_nxt;
    end

    rcs_recip_div u_div (
      .clk     (clk),
      .en      (en[DIV_BASE +: DIV_STAGES]),
      .ray_i   (ray_r),
      .ray_o   (ray_d),
      .delta_o (delta_d)
    );

    // Side multiply: distance from the player to the first grid line
    assign frac = {1'b0, pos_r[a][FRAC_W-1:0]};
    assign f    = ray_d[RAY_W-1] ? frac : (17'h10000 - frac);

    always_ff @(posedge clk) begin
      if (en[MUL_STG]) begin
        ray_m_r     <= ray_d;
        delta_m_r   <= delta_d;
        side_prod_r <= PROD_W'(f) * PROD_W'(delta_d);
      end
    end

    assign side_full = side_prod_r[PROD_W-1:FRAC_W];

    // Output register
    always_ff @(posedge clk) begin
      if (en[NST-1]) begin
        ray_out_r[a]   <= ray_m_r;
        cell_out_r[a]  <= pos_r[a][POS_W-1:FRAC_W];
        delta_out_r[a] <= delta_m_r;
        side_out_r[a]  <= (|side_full[PROD_W-FRAC_W-1:DIST_W]) ? DIST_SAT
                                                                : side_full[DIST_W-1:0];
      end
    end
  end

  assign out_ray_x      = ray_out_r[0];
  assign out_ray_y      = ray_out_r[1];
  assign out_cell_x     = cell_out_r[0];
  assign out_cell_y     = cell_out_r[1];
  assign out_step_x_neg = ray_out_r[0][RAY_W-1];
  assign out_step_y_neg = ray_out_r[1][RAY_W-1];
  assign out_delta_x    = delta_out_r[0];
  assign out_delta_y    = delta_out_r[1];
  assign out_side_x     = side_out_r[0];
  assign out_side_y     = side_out_r[1];

  // ---------------------------------------------------------- assertions
  a_empty_front_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> !in_stall)
    else $error("input stalled with an empty first stage");

  a_free_sink_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output is not stalled");

  a_zero_ray_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_ray_x == '0)) |-> (out_delta_x == DIST_SAT))
    else $error("zero ray x without saturated delta");

  a_delta_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_delta_x != '0) && (out_delta_y != '0)))
    else $error("delta of zero on a valid item");

endmodule

`default_nettype wire
